FILE: rtl/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared constants, register indexes and the configuration bundle of the
// barycentric triangle fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package btf_pkg;

  // coordinate and sample widths
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned SampleBits = 8;

  // register file layout
  localparam int unsigned PosWidth    = 2 * CoordBits;
  localparam int unsigned ValWidth    = SampleBits;
  localparam int unsigned InvWidth    = 32;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned AddrWidth   = 5;
  localparam int unsigned RegIdxWidth = AddrWidth - 2;

  // datapath widths
  localparam int unsigned DiffWidth   = CoordBits + 1;
  localparam int unsigned ProdWidth   = 2 * DiffWidth;
  localparam int unsigned EdgeWidth   = ProdWidth + 1;
  localparam int unsigned MulWidth    = InvWidth + EdgeWidth;
  localparam int unsigned WeightWidth = 32;
  localparam int unsigned W3Width     = WeightWidth + 2;
  localparam int unsigned SampWidth   = SampleBits + 1;
  localparam int unsigned BlendWidth  = W3Width + SampWidth;
  localparam int unsigned AccWidth    = BlendWidth + 2;
  localparam int unsigned RoundShift  = 14;
  localparam int unsigned ShWidth     = AccWidth - RoundShift;
  localparam int unsigned OutWidth    = 26;

  // fixed-point constants
  localparam logic signed [W3Width-1:0]  Q30One      = W3Width'(64'sd1073741824);
  localparam logic signed [W3Width-1:0]  WeightFloor = -W3Width'(64'sd10737418);
  localparam logic signed [AccWidth-1:0] RoundBias   = AccWidth'(64'sd8192);
  localparam logic signed [ShWidth-1:0]  OutMax      = ShWidth'(64'sd33554431);
  localparam logic signed [ShWidth-1:0]  OutMin      = -ShWidth'(64'sd33554432);

  // register indexes
  typedef enum logic [RegIdxWidth-1:0] {
    RegPosA   = 3'd0,
    RegPosB   = 3'd1,
    RegPosC   = 3'd2,
    RegValA   = 3'd3,
    RegValB   = 3'd4,
    RegValC   = 3'd5,
    RegInvDet = 3'd6
  } btf_reg_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [CoordBits-1:0]       x1;
    logic [CoordBits-1:0]       y1;
    logic [CoordBits-1:0]       x2;
    logic [CoordBits-1:0]       y2;
    logic [CoordBits-1:0]       x3;
    logic [CoordBits-1:0]       y3;
    logic [SampleBits-1:0]      va;
    logic [SampleBits-1:0]      vb;
    logic [SampleBits-1:0]      vc;
    logic signed [InvWidth-1:0] inv;
  } btf_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/btf_datapath.sv
// ----------------------------------------------------------------------------
// btf_datapath
// Seven-stage pipeline: bounding box, edge products, edge sums, weight
// products, weight saturation and test, blend products, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module btf_datapath import btf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  btf_cfg_t                   cfg_i,
  input  logic                       in_valid_i,
  input  logic [CoordBits-1:0]       px_i,
  input  logic [CoordBits-1:0]       py_i,
  input  logic                       empty_i,
  output logic                       out_valid_o,
  output logic                       write_enable_o,
  output logic signed [OutWidth-1:0] blended_value_o
);

  // ---- stage 1: bounding box and pixel offsets ----
  logic [CoordBits-1:0] lo_x, hi_x, lo_y, hi_y;
  logic in_box;
  logic signed [DiffWidth-1:0] s1_dx_d, s1_dy_d;
  logic signed [DiffWidth-1:0] s1_dx_q, s1_dy_q;
  logic s1_valid_q, s1_gate_q, s1_gate_d;

  always_comb begin
    lo_x = cfg_i.x1;
    hi_x = cfg_i.x1;
    lo_y = cfg_i.y1;
    hi_y = cfg_i.y1;
    if (cfg_i.x2 < lo_x) lo_x = cfg_i.x2;
    if (cfg_i.x3 < lo_x) lo_x = cfg_i.x3;
    if (cfg_i.x2 > hi_x) hi_x = cfg_i.x2;
    if (cfg_i.x3 > hi_x) hi_x = cfg_i.x3;
    if (cfg_i.y2 < lo_y) lo_y = cfg_i.y2;
    if (cfg_i.y3 < lo_y) lo_y = cfg_i.y3;
    if (cfg_i.y2 > hi_y) hi_y = cfg_i.y2;
    if (cfg_i.y3 > hi_y) hi_y = cfg_i.y3;
    in_box = (px_i >= lo_x) && (px_i <= hi_x) && (py_i >= lo_y) && (py_i <= hi_y);
    s1_gate_d = empty_i && (cfg_i.inv != '0) && in_box;
    s1_dx_d = $signed({1'b0, px_i}) - $signed({1'b0, cfg_i.x3});
    s1_dy_d = $signed({1'b0, py_i}) - $signed({1'b0, cfg_i.y3});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_gate_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s1_gate_q  <= s1_gate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q <= s1_dx_d;
    s1_dy_q <= s1_dy_d;
  end

  // ---- stage 2: edge products ----
  logic signed [DiffWidth-1:0] dy23, dx32, dy31, dx13;
  logic signed [ProdWidth-1:0] s2_p11_q, s2_p12_q, s2_p21_q, s2_p22_q;
  logic s2_valid_q, s2_gate_q;

  assign dy23 = $signed({1'b0, cfg_i.y2}) - $signed({1'b0, cfg_i.y3});
  assign dx32 = $signed({1'b0, cfg_i.x3}) - $signed({1'b0, cfg_i.x2});
  assign dy31 = $signed({1'b0, cfg_i.y3}) - $signed({1'b0, cfg_i.y1});
  assign dx13 = $signed({1'b0, cfg_i.x1}) - $signed({1'b0, cfg_i.x3});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_gate_q  <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_gate_q  <= s1_gate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_p11_q <= ProdWidth'(dy23) * ProdWidth'(s1_dx_q);
    s2_p12_q <= ProdWidth'(dx32) * ProdWidth'(s1_dy_q);
    s2_p21_q <= ProdWidth'(dy31) * ProdWidth'(s1_dx_q);
    s2_p22_q <= ProdWidth'(dx13) * ProdWidth'(s1_dy_q);
  end

  // ---- stage 3: edge sums ----
  logic signed [EdgeWidth-1:0] s3_e1_q, s3_e2_q;
  logic s3_valid_q, s3_gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s3_gate_q  <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
      s3_gate_q  <= s2_gate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_e1_q <= EdgeWidth'(s2_p11_q) + EdgeWidth'(s2_p12_q);
    s3_e2_q <= EdgeWidth'(s2_p21_q) + EdgeWidth'(s2_p22_q);
  end

  // ---- stage 4: weights times inverse determinant ----
  logic signed [MulWidth-1:0] s4_m1_q, s4_m2_q;
  logic s4_valid_q, s4_gate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s4_gate_q  <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
      s4_gate_q  <= s3_gate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_m1_q <= MulWidth'(cfg_i.inv) * MulWidth'(s3_e1_q);
    s4_m2_q <= MulWidth'(cfg_i.inv) * MulWidth'(s3_e2_q);
  end

  // ---- stage 5: saturate to Q1.30, third weight, inside test ----
  logic signed [WeightWidth-1:0] w1_d, w2_d;
  logic signed [W3Width-1:0]     w3_d;
  logic                          s5_pass_d;
  logic signed [WeightWidth-1:0] s5_w1_q, s5_w2_q;
  logic signed [W3Width-1:0]     s5_w3_q;
  logic s5_valid_q, s5_pass_q;

  always_comb begin
    // upper bits must all match the sign of the kept word
    if (&s4_m1_q[MulWidth-1:WeightWidth-1] || ~|s4_m1_q[MulWidth-1:WeightWidth-1]) begin
      w1_d = s4_m1_q[WeightWidth-1:0];
    end else if (s4_m1_q[MulWidth-1]) begin
      w1_d = {1'b1, {(WeightWidth-1){1'b0}}};
    end else begin
      w1_d = {1'b0, {(WeightWidth-1){1'b1}}};
    end
    if (&s4_m2_q[MulWidth-1:WeightWidth-1] || ~|s4_m2_q[MulWidth-1:WeightWidth-1]) begin
      w2_d = s4_m2_q[WeightWidth-1:0];
    end else if (s4_m2_q[MulWidth-1]) begin
      w2_d = {1'b1, {(WeightWidth-1){1'b0}}};
    end else begin
      w2_d = {1'b0, {(WeightWidth-1){1'b1}}};
    end
    w3_d = Q30One - W3Width'(w1_d) - W3Width'(w2_d);
    s5_pass_d = s4_gate_q
             && (W3Width'(w1_d) >= WeightFloor)
             && (W3Width'(w2_d) >= WeightFloor)
             && (w3_d >= WeightFloor);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s5_pass_q  <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
      s5_pass_q  <= s5_pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_w1_q <= w1_d;
    s5_w2_q <= w2_d;
    s5_w3_q <= w3_d;
  end

  // ---- stage 6: weight times vertex sample ----
  logic signed [SampWidth-1:0]  va_s, vb_s, vc_s;
  logic signed [BlendWidth-1:0] s6_b1_q, s6_b2_q, s6_b3_q;
  logic s6_valid_q, s6_pass_q;

  assign va_s = $signed({1'b0, cfg_i.va});
  assign vb_s = $signed({1'b0, cfg_i.vb});
  assign vc_s = $signed({1'b0, cfg_i.vc});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
      s6_pass_q  <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
      s6_pass_q  <= s5_pass_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_b1_q <= BlendWidth'(s5_w1_q) * BlendWidth'(va_s);
    s6_b2_q <= BlendWidth'(s5_w2_q) * BlendWidth'(vb_s);
    s6_b3_q <= BlendWidth'(s5_w3_q) * BlendWidth'(vc_s);
  end

  // ---- stage 7: sum, round half up to Q.16, saturate ----
  logic signed [AccWidth-1:0] acc;
  logic signed [ShWidth-1:0]  shifted;
  logic signed [OutWidth-1:0] res_d;
  logic signed [OutWidth-1:0] out_value_q;
  logic out_valid_q, out_write_q;

  always_comb begin
    acc = AccWidth'(s6_b1_q) + AccWidth'(s6_b2_q) + AccWidth'(s6_b3_q) + RoundBias;
    shifted = ShWidth'(acc >>> RoundShift);
    if (shifted > OutMax) begin
      res_d = OutMax[OutWidth-1:0];
    end else if (shifted < OutMin) begin
      res_d = OutMin[OutWidth-1:0];
    end else begin
      res_d = shifted[OutWidth-1:0];
    end
    if (!s6_pass_q) res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_write_q <= 1'b0;
    end else begin
      out_valid_q <= s6_valid_q;
      out_write_q <= s6_valid_q && s6_pass_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = out_write_q;
  assign blended_value_o = out_value_q;

  // ---- checks ----
  a_write_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> out_valid_o)
    else $error("write_enable without a result strobe");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (blended_value_o == '0))
    else $error("non-written result carries a value");

  a_valid_travels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |=> ##3 out_valid_o)
    else $error("item lost between edge sum and output");

  a_pass_needs_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_pass_q |-> $past(s4_gate_q))
    else $error("weight test passed for a gated pixel");

endmodule

`default_nettype wire

FILE: rtl/barycentric_triangle_fill.sv
// ----------------------------------------------------------------------------
// barycentric_triangle_fill
// Per-pixel barycentric interpolation over a configured triangle, with an
// APB register file and a seven-stage arithmetic pipeline.
//
//   channel   | signals                                        | direction
//   ----------+------------------------------------------------+----------
//   config    | psel penable pwrite paddr pwdata prdata pready | slave
//   pixel     | start_i busy_o pixel_x_i pixel_y_i             | in
//             | cell_is_empty_i                                |
//   result    | done_o write_enable_o blended_value_o          | out
//
// A pixel transaction is taken whenever start_i is high; busy_o stays low, so
// one pixel per cycle is sustained by the pipeline.
// done_o rises when the result leaves the last register and holds for one cycle:
// seven register stages, the first loaded at the accepting edge, three of them multipliers.
// Reset clears the configuration registers and the valid flags, which empties the pipeline; no clearing pass.
// The result side has no back-pressure: every result is shown exactly once.
// ----------------------------------------------------------------------------
`default_nettype none

module barycentric_triangle_fill import btf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AddrWidth-1:0]       paddr,
  input  logic [DataWidth-1:0]       pwdata,
  output logic [DataWidth-1:0]       prdata,
  output logic                       pready,
  // pixel channel
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [CoordBits-1:0]       pixel_x_i,
  input  logic [CoordBits-1:0]       pixel_y_i,
  input  logic                       cell_is_empty_i,
  // result channel
  output logic                       done_o,
  output logic                       write_enable_o,
  output logic signed [OutWidth-1:0] blended_value_o
);

  // register file
  logic [PosWidth-1:0] pos_a_q, pos_b_q, pos_c_q;
  logic [ValWidth-1:0] val_a_q, val_b_q, val_c_q;
  logic [InvWidth-1:0] inv_det_q;
  logic                cfg_write;
  btf_reg_e            reg_idx;

  assign cfg_write = psel && penable && pwrite;
  assign reg_idx   = btf_reg_e'(paddr[AddrWidth-1:2]);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_a_q   <= '0;
      pos_b_q   <= '0;
      pos_c_q   <= '0;
      val_a_q   <= '0;
      val_b_q   <= '0;
      val_c_q   <= '0;
      inv_det_q <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        RegPosA:   pos_a_q   <= pwdata[PosWidth-1:0];
        RegPosB:   pos_b_q   <= pwdata[PosWidth-1:0];
        RegPosC:   pos_c_q   <= pwdata[PosWidth-1:0];
        RegValA:   val_a_q   <= pwdata[ValWidth-1:0];
        RegValB:   val_b_q   <= pwdata[ValWidth-1:0];
        RegValC:   val_c_q   <= pwdata[ValWidth-1:0];
        RegInvDet: inv_det_q <= pwdata[InvWidth-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegPosA:   prdata = DataWidth'(pos_a_q);
      RegPosB:   prdata = DataWidth'(pos_b_q);
      RegPosC:   prdata = DataWidth'(pos_c_q);
      RegValA:   prdata = DataWidth'(val_a_q);
      RegValB:   prdata = DataWidth'(val_b_q);
      RegValC:   prdata = DataWidth'(val_c_q);
      RegInvDet: prdata = DataWidth'(inv_det_q);
      default:   prdata = '0;
    endcase
  end

  // unpack the configuration for the pipeline
  btf_cfg_t cfg;

  always_comb begin
    cfg.x1  = pos_a_q[CoordBits-1:0];
    cfg.y1  = pos_a_q[2*CoordBits-1:CoordBits];
    cfg.x2  = pos_b_q[CoordBits-1:0];
    cfg.y2  = pos_b_q[2*CoordBits-1:CoordBits];
    cfg.x3  = pos_c_q[CoordBits-1:0];
    cfg.y3  = pos_c_q[2*CoordBits-1:CoordBits];
    cfg.va  = val_a_q[SampleBits-1:0];
    cfg.vb  = val_b_q[SampleBits-1:0];
    cfg.vc  = val_c_q[SampleBits-1:0];
    cfg.inv = $signed(inv_det_q);
  end

  // pipeline takes a pixel every cycle
  assign busy_o = 1'b0;

  btf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (start_i && !busy_o),
    .px_i            (pixel_x_i),
    .py_i            (pixel_y_i),
    .empty_i         (cell_is_empty_i),
    .out_valid_o     (done_o),
    .write_enable_o  (write_enable_o),
    .blended_value_o (blended_value_o)
  );

endmodule

`default_nettype wire
